@@ sv/sscsd_pkg.sv @@
// shared types, constants and frame-building functions for the seven-segment shift driver
package sscsd_pkg;

    localparam int FRAME_BITS  = 16;
    localparam int DIGIT_COUNT = 4;
    localparam int BIT_W       = $clog2(FRAME_BITS);
    localparam int POS_W       = $clog2(DIGIT_COUNT);

    localparam int MINUTES_W    = 13;
    localparam int HOURS_W      = 7;
    localparam int MINS_W       = 6;
    localparam int DIGIT_W      = 4;
    localparam int S_TDATA_W    = 16;
    localparam int M_TDATA_W    = 8;

    localparam logic [MINUTES_W-1:0] MINUTES_MAX      = 13'd5999;
    localparam int                   MINUTES_PER_HOUR = 60;
    localparam int                   DECIMAL_BASE     = 10;

    localparam logic [7:0] SELECT_FIRST = 8'h08;
    localparam logic [POS_W-1:0] DP_POS = 2'd1;

    typedef logic [DIGIT_COUNT-1:0][DIGIT_W-1:0] digit_array_t;
    typedef logic [FRAME_BITS-1:0]               frame_t;

    // control from the sequencer to the serializer
    typedef struct packed {
        logic         start;
        logic         counting;
        digit_array_t digits;
    } shift_ctl_t;

    // active-low segment pattern, decimal point in bit 0
    function automatic logic [7:0] seg_pattern(input logic [DIGIT_W-1:0] value);
        logic [7:0] seg;
        unique case (value)
            4'd0:    seg = 8'h03;
            4'd1:    seg = 8'h9F;
            4'd2:    seg = 8'h25;
            4'd3:    seg = 8'h0D;
            4'd4:    seg = 8'h99;
            4'd5:    seg = 8'h49;
            4'd6:    seg = 8'h41;
            4'd7:    seg = 8'h1F;
            4'd8:    seg = 8'h01;
            4'd9:    seg = 8'h09;
            default: seg = 8'h03;
        endcase
        return seg;
    endfunction

    function automatic frame_t build_frame(input logic [POS_W-1:0]   pos,
                                           input logic [DIGIT_W-1:0] value);
        frame_t frame;
        frame = {SELECT_FIRST >> pos, seg_pattern(value)};
        if (pos == DP_POS) begin
            frame[0] = 1'b0;
        end
        return frame;
    endfunction

endpackage

@@ sv/seven_segment_clock_shift_driver.sv @@
// top level: four-digit seven-segment clock driver producing serial shift frames
//
// Input channel (s_): one request carries an elapsed minute count and a
// one-second flag. Result channel (m_): one serial bit per transfer, 64 per
// request: four 16-bit frames (digit select in the high byte, active-low
// segments in the low byte), msb first. m_tuser marks the 16th bit of each
// frame (pulse the display latch), m_tlast the final bit of the run.
// cfg_wr_en/cfg_wr_data write the counting enable; write it only when idle.
// When counting and the flag is set, minutes are clamped to 99:59 and split
// into digits by a bit-serial divide by 60 followed by bit-serial divides by
// 10; the start strobe then passes through shift_start_reg before the
// serializer loads its first frame. Without an update the request goes
// straight to shift_start_reg. Bits then leave at one per cycle while
// m_tready is high, set by the frame shift register. One request is handled
// at a time: s_tready is high only while idle. A stall on m_tready holds the
// current bit and stretches the run. Reset clears the stored digits to zero
// and counting to off.
module seven_segment_clock_shift_driver (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic                            cfg_wr_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [12:0] minutes_elapsed, [13] second_passed, [15:14] zero
    input  logic [sscsd_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] serial_bit, [7:1] zero
    output logic [sscsd_pkg::M_TDATA_W-1:0] m_tdata,
    // [0] latch_after
    output logic                            m_tuser,
    output logic                            m_tlast
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_HOURS  = 4'b0010,
        ST_DIGITS = 4'b0100,
        ST_SHIFT  = 4'b1000
    } state_t;

    state_t                  state_reg, state_next;
    logic                    counting_reg;
    sscsd_pkg::digit_array_t digits_reg, digits_next;
    logic                    shift_start_reg, shift_start_next;

    logic                                accept;
    logic [sscsd_pkg::MINUTES_W-1:0]     minutes_in;
    logic [sscsd_pkg::MINUTES_W-1:0]     minutes_clamped;
    logic                                update;

    logic                                div60_start;
    logic                                div60_done;
    logic [sscsd_pkg::MINUTES_W-1:0]     div60_quot;
    logic [sscsd_pkg::MINS_W-1:0]        div60_rem;

    logic                                div10_start;
    logic                                div_h_done;
    logic                                div_m_done;
    logic [sscsd_pkg::HOURS_W-1:0]       div_h_quot;
    logic [sscsd_pkg::DIGIT_W-1:0]       div_h_rem;
    logic [sscsd_pkg::HOURS_W-1:0]       div_m_quot;
    logic [sscsd_pkg::DIGIT_W-1:0]       div_m_rem;

    sscsd_pkg::shift_ctl_t               shift_ctl;
    logic                                shift_done;
    logic                                shift_bit;
    logic                                shift_frame_end;
    logic                                shift_run_end;

    assign s_tready        = (state_reg == ST_IDLE);
    assign accept          = s_tvalid && s_tready;
    assign minutes_in      = s_tdata[sscsd_pkg::MINUTES_W-1:0];
    assign minutes_clamped = (minutes_in > sscsd_pkg::MINUTES_MAX) ?
                             sscsd_pkg::MINUTES_MAX : minutes_in;
    assign update          = counting_reg && s_tdata[sscsd_pkg::MINUTES_W];

    assign div60_start = accept && update;
    assign div10_start = (state_reg == ST_HOURS) && div60_done;

    always_comb begin
        state_next       = state_reg;
        digits_next      = digits_reg;
        shift_start_next = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (update) begin
                        state_next = ST_HOURS;
                    end else begin
                        state_next       = ST_SHIFT;
                        shift_start_next = 1'b1;
                    end
                end
            end
            ST_HOURS: begin
                if (div60_done) begin
                    state_next = ST_DIGITS;
                end
            end
            ST_DIGITS: begin
                if (div_h_done && div_m_done) begin
                    digits_next[0]   = div_h_quot[sscsd_pkg::DIGIT_W-1:0];
                    digits_next[1]   = div_h_rem;
                    digits_next[2]   = div_m_quot[sscsd_pkg::DIGIT_W-1:0];
                    digits_next[3]   = div_m_rem;
                    state_next       = ST_SHIFT;
                    shift_start_next = 1'b1;
                end
            end
            ST_SHIFT: begin
                if (shift_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            counting_reg    <= 1'b0;
            digits_reg      <= '0;
            shift_start_reg <= 1'b0;
        end else begin
            state_reg       <= state_next;
            digits_reg      <= digits_next;
            shift_start_reg <= shift_start_next;
            if (cfg_wr_en) begin
                counting_reg <= cfg_wr_data;
            end
        end
    end

    // minutes -> hours and minutes
    sscsd_div #(
        .N       (sscsd_pkg::MINUTES_W),
        .R_W     (sscsd_pkg::MINS_W),
        .DIVISOR (sscsd_pkg::MINUTES_PER_HOUR)
    ) u_div60 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div60_start),
        .dividend  (minutes_clamped),
        .done      (div60_done),
        .quotient  (div60_quot),
        .remainder (div60_rem)
    );

    // hours -> tens and units
    sscsd_div #(
        .N       (sscsd_pkg::HOURS_W),
        .R_W     (sscsd_pkg::DIGIT_W),
        .DIVISOR (sscsd_pkg::DECIMAL_BASE)
    ) u_div_hours (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div10_start),
        .dividend  (div60_quot[sscsd_pkg::HOURS_W-1:0]),
        .done      (div_h_done),
        .quotient  (div_h_quot),
        .remainder (div_h_rem)
    );

    // minutes -> tens and units, same length as the hours divide
    sscsd_div #(
        .N       (sscsd_pkg::HOURS_W),
        .R_W     (sscsd_pkg::DIGIT_W),
        .DIVISOR (sscsd_pkg::DECIMAL_BASE)
    ) u_div_mins (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div10_start),
        .dividend  ({{(sscsd_pkg::HOURS_W - sscsd_pkg::MINS_W){1'b0}}, div60_rem}),
        .done      (div_m_done),
        .quotient  (div_m_quot),
        .remainder (div_m_rem)
    );

    assign shift_ctl.start    = shift_start_reg;
    assign shift_ctl.counting = counting_reg;
    assign shift_ctl.digits   = digits_reg;

    sscsd_shift u_shift (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (shift_ctl),
        .done        (shift_done),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_bit       (shift_bit),
        .m_frame_end (shift_frame_end),
        .m_run_end   (shift_run_end)
    );

    assign m_tdata = {{(sscsd_pkg::M_TDATA_W - 1){1'b0}}, shift_bit};
    assign m_tuser = shift_frame_end;
    assign m_tlast = shift_run_end;

endmodule

@@ sv/sscsd_div.sv @@
// bit-serial restoring divider by a constant, one quotient bit per cycle
module sscsd_div #(
    parameter int N       = 13,
    parameter int R_W     = 6,
    parameter int DIVISOR = 60
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [N-1:0]   dividend,
    output logic           done,
    output logic [N-1:0]   quotient,
    output logic [R_W-1:0] remainder
);

    localparam int CNT_W = $clog2(N + 1);

    logic [N-1:0]     q_reg, q_next;
    logic [R_W-1:0]   rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [R_W:0] trial;
    logic [R_W:0] diff;
    logic         ge;

    assign trial = {rem_reg, q_reg[N-1]};
    assign ge    = (trial >= (R_W + 1)'(DIVISOR));
    assign diff  = trial - (R_W + 1)'(DIVISOR);

    always_comb begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            q_next    = dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(N);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            q_next   = {q_reg[N-2:0], ge};
            rem_next = ge ? diff[R_W-1:0] : trial[R_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg   <= q_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = rem_reg;

endmodule

@@ sv/sscsd_shift.sv @@
// frame serializer: four 16-bit digit frames shifted out msb first
module sscsd_shift (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sscsd_pkg::shift_ctl_t ctl,
    output logic                  done,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic                  m_bit,
    output logic                  m_frame_end,
    output logic                  m_run_end
);

    logic                           active_reg, active_next;
    sscsd_pkg::frame_t              frame_reg, frame_next;
    logic [sscsd_pkg::BIT_W-1:0]    bit_reg, bit_next;
    logic [sscsd_pkg::POS_W-1:0]    pos_reg, pos_next;

    logic                           fire;
    logic                           frame_end;
    logic                           run_end;
    logic [sscsd_pkg::POS_W-1:0]    pos_inc;
    logic [sscsd_pkg::DIGIT_W-1:0]  first_val;
    logic [sscsd_pkg::DIGIT_W-1:0]  next_val;

    assign fire      = active_reg && m_tready;
    assign frame_end = (bit_reg == sscsd_pkg::BIT_W'(sscsd_pkg::FRAME_BITS - 1));
    assign run_end   = frame_end && (pos_reg == sscsd_pkg::POS_W'(sscsd_pkg::DIGIT_COUNT - 1));
    assign pos_inc   = pos_reg + 1'b1;

    // idle mode shows zero on every digit
    assign first_val = ctl.counting ? ctl.digits[0] : '0;
    assign next_val  = ctl.counting ? ctl.digits[pos_inc] : '0;

    always_comb begin
        active_next = active_reg;
        frame_next  = frame_reg;
        bit_next    = bit_reg;
        pos_next    = pos_reg;
        if (ctl.start) begin
            active_next = 1'b1;
            frame_next  = sscsd_pkg::build_frame('0, first_val);
            bit_next    = '0;
            pos_next    = '0;
        end else if (fire) begin
            if (run_end) begin
                active_next = 1'b0;
            end else if (frame_end) begin
                pos_next   = pos_inc;
                frame_next = sscsd_pkg::build_frame(pos_inc, next_val);
                bit_next   = '0;
            end else begin
                frame_next = {frame_reg[sscsd_pkg::FRAME_BITS-2:0], 1'b0};
                bit_next   = bit_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            bit_reg    <= '0;
            pos_reg    <= '0;
        end else begin
            active_reg <= active_next;
            bit_reg    <= bit_next;
            pos_reg    <= pos_next;
        end
        frame_reg <= frame_next;
    end

    assign done        = fire && run_end;
    assign m_tvalid    = active_reg;
    assign m_bit       = frame_reg[sscsd_pkg::FRAME_BITS-1];
    assign m_frame_end = frame_end;
    assign m_run_end   = run_end;

endmodule

@@ sv/sscsd_checker.sv @@
// port-level checker for the seven-segment shift driver, bound to the top level
module sscsd_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [sscsd_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                            m_tuser,
    input logic                            m_tlast
);

    // no bit pending right after reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // the run end is always a frame end
    a_last_is_latch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser)
        else $error("run end without frame latch");

    // one request at a time: no new request while bits are pending
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("request taken while bits pending");

    // the run stops after its final bit
    a_run_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid)
        else $error("bits continue after run end");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind seven_segment_clock_shift_driver sscsd_checker u_sscsd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
